@@ rtl/iida_pkg.sv @@
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and codes for the indexed insert/delete array.
// ----------------------------------------------------------------------------
`default_nettype none

package iida_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int WORD_W = 32;
  localparam int POS_W  = 8;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 6;
  localparam int FILL_W = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_INS  = 2'd1;
  localparam cell_op_t OP_DEL  = 2'd2;
  localparam cell_op_t OP_ROT  = 2'd3;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last_idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/indexed_insert_delete_array_top.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top
// Packed ordered array of signed words with insert, delete and read out.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  req     | req_valid, req_stall | action, position, new_word
//  rsp     | rsp_valid, rsp_stall | status, has_word, word_out, slot_out,
//          |                      | fill_count, last
//
// Insert and delete shift every cell at or past the position at once.
// Read out of N entries holds the request side until the last entry has gone
// out: the chain rotates by one slot per cycle while the response is not
// stalled, and the head cell feeds the output. An empty array answers with no word.
// Reset clears count, state and rsp_valid; cells are undefined until written.
// A stalled response holds the output register and stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_delete_array_top #(
  parameter int DEPTH = iida_pkg::DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                req_valid,
  output logic                               req_stall,
  input  wire [iida_pkg::ACT_W-1:0]          action,
  input  wire [iida_pkg::POS_W-1:0]          position,
  input  wire signed [iida_pkg::WORD_W-1:0]  new_word,
  output logic                               rsp_valid,
  input  wire                                rsp_stall,
  output logic [iida_pkg::STAT_W-1:0]        status,
  output logic                               has_word,
  output logic signed [iida_pkg::WORD_W-1:0] word_out,
  output logic [iida_pkg::SLOT_W-1:0]        slot_out,
  output logic [iida_pkg::FILL_W-1:0]        fill_count,
  output logic                               last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                        state;
  logic                        state_next;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            last_rd;
  logic [iida_pkg::POS_W-1:0]  count8;
  logic [iida_pkg::POS_W-1:0]  ins_pos;
  logic [iida_pkg::WORD_W-1:0] head_word;
  logic                        out_free;
  logic                        acc;
  logic                        full;
  logic                        rd_step;
  logic                        rd_end;
  iida_pkg::cell_ctrl_t        ctrl;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign acc       = req_valid && !req_stall;
  assign count8    = iida_pkg::POS_W'(count);
  assign full      = (count == CNT_W'(DEPTH));
  assign ins_pos   = (position > count8) ? count8 : position;
  assign last_rd   = IDX_W'(count - CNT_W'(1));
  assign rd_step   = (state == S_READ) && out_free;
  assign rd_end    = (rd_idx == last_rd);

  always_comb begin
    ctrl.op       = iida_pkg::OP_HOLD;
    ctrl.pos      = position;
    ctrl.last_idx = iida_pkg::POS_W'(last_rd);
    count_next    = count;
    state_next    = state;
    if (acc) begin
      unique case (action)
        iida_pkg::ACT_INSERT: begin
          if (!full) begin
            ctrl.op    = iida_pkg::OP_INS;
            ctrl.pos   = ins_pos;
            count_next = count + CNT_W'(1);
          end
        end
        iida_pkg::ACT_DELETE: begin
          if (position < count8) begin
            ctrl.op    = iida_pkg::OP_DEL;
            count_next = count - CNT_W'(1);
          end
        end
        iida_pkg::ACT_READ: begin
          if (count != '0) begin
            state_next = S_READ;
          end
        end
        default: begin
        end
      endcase
    end else if (rd_step) begin
      ctrl.op = iida_pkg::OP_ROT;
      if (rd_end) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (acc) begin
        rd_idx <= '0;
      end else if (rd_step) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (acc) begin
        rsp_valid <= !((action == iida_pkg::ACT_READ) && (count != '0));
      end else if (rd_step) begin
        rsp_valid <= 1'b1;
      end else if (out_free) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      has_word   <= 1'b0;
      word_out   <= '0;
      slot_out   <= '0;
      fill_count <= iida_pkg::FILL_W'(count_next);
      last       <= 1'b1;
      if ((action == iida_pkg::ACT_INSERT) && full) begin
        status <= iida_pkg::ST_FULL;
      end else if ((action == iida_pkg::ACT_DELETE) && !(position < count8)) begin
        status <= iida_pkg::ST_BADPOS;
      end else begin
        status <= iida_pkg::ST_OK;
      end
    end else if (rd_step) begin
      status     <= iida_pkg::ST_OK;
      has_word   <= 1'b1;
      word_out   <= head_word;
      slot_out   <= iida_pkg::SLOT_W'(rd_idx);
      fill_count <= iida_pkg::FILL_W'(count);
      last       <= rd_end;
    end
  end

  iida_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .new_word  (new_word),
    .head_word (head_word)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> req_stall)
    else $error("request taken during read out");

  a_word_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && has_word) |-> (status == iida_pkg::ST_OK))
    else $error("read out transaction with error status");

  a_read_enter: assert property (@(posedge clk) disable iff (rst)
    (acc && (action == iida_pkg::ACT_READ) && (count != '0)) |=>
      ((state == S_READ) && (rd_idx == '0)))
    else $error("read out did not start");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("fill count moved during read out");

endmodule

`default_nettype wire

@@ rtl/iida_cell.sv @@
// ----------------------------------------------------------------------------
// iida_cell
// One slot of the array: holds a word, takes one from a neighbor, or loads the new or wrapped word.
// ----------------------------------------------------------------------------
`default_nettype none

module iida_cell #(
  parameter int IDX = 0
) (
  input  wire                         clk,
  input  wire iida_pkg::cell_ctrl_t   ctrl,
  input  wire [iida_pkg::WORD_W-1:0]  left_word,
  input  wire [iida_pkg::WORD_W-1:0]  right_word,
  input  wire [iida_pkg::WORD_W-1:0]  wrap_word,
  input  wire [iida_pkg::WORD_W-1:0]  new_word,
  output logic [iida_pkg::WORD_W-1:0] word
);

  localparam logic [iida_pkg::POS_W-1:0] IDX8 = iida_pkg::POS_W'(IDX);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      iida_pkg::OP_INS: begin
        if (IDX8 > ctrl.pos) begin
          word <= left_word;
        end else if (IDX8 == ctrl.pos) begin
          word <= new_word;
        end
      end
      iida_pkg::OP_DEL: begin
        if (IDX8 >= ctrl.pos) begin
          word <= right_word;
        end
      end
      iida_pkg::OP_ROT: begin
        if (IDX8 == ctrl.last_idx) begin
          word <= wrap_word;
        end else if (IDX8 < ctrl.last_idx) begin
          word <= right_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/iida_chain.sv @@
// ----------------------------------------------------------------------------
// iida_chain
// Row of cells wired to their neighbors; slot 0 is the head.
// ----------------------------------------------------------------------------
`default_nettype none

module iida_chain #(
  parameter int DEPTH = iida_pkg::DEPTH_DEF
) (
  input  wire                         clk,
  input  wire iida_pkg::cell_ctrl_t   ctrl,
  input  wire [iida_pkg::WORD_W-1:0]  new_word,
  output logic [iida_pkg::WORD_W-1:0] head_word
);

  logic [iida_pkg::WORD_W-1:0] words   [DEPTH];
  logic [iida_pkg::WORD_W-1:0] left_w  [DEPTH];
  logic [iida_pkg::WORD_W-1:0] right_w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = words[g+1];
    end

    iida_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_word  (left_w[g]),
      .right_word (right_w[g]),
      .wrap_word  (words[0]),
      .new_word   (new_word),
      .word       (words[g])
    );
  end

  assign head_word = words[0];

endmodule

`default_nettype wire
